@@ rtl/core/lmfs_pkg.sv @@
package lmfs_pkg;

    localparam int unsigned PANEL_WORDS = 16;
    localparam int unsigned WORD_BITS   = 16;
    localparam int unsigned WORD_AW     = $clog2(PANEL_WORDS);
    localparam int unsigned BIT_AW      = $clog2(WORD_BITS);
    localparam int unsigned COORD_W     = 16;

    // Command codes; code 3 is unused and falls to a default arm.
    typedef enum logic [1:0] {
        CMD_SET_PIXEL = 2'd0,
        CMD_FILL      = 2'd1,
        CMD_SCAN      = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_SCAN
    } t_state;

    // Chain base positions of each column, top and bottom halves.
    localparam logic [7:0] UPPER_BASE [PANEL_WORDS] = '{
        8'd254, 8'd14, 8'd253, 8'd13, 8'd250, 8'd10, 8'd249, 8'd9,
        8'd246, 8'd6,  8'd245, 8'd5,  8'd242, 8'd2,  8'd241, 8'd1
    };
    localparam logic [7:0] LOWER_BASE [PANEL_WORDS] = '{
        8'd255, 8'd15, 8'd252, 8'd12, 8'd251, 8'd11, 8'd248, 8'd8,
        8'd247, 8'd7,  8'd244, 8'd4,  8'd243, 8'd3,  8'd240, 8'd0
    };

    typedef struct packed {
        logic               in_range;
        logic [WORD_AW-1:0] word;
        logic [BIT_AW-1:0]  bit_idx;
    } t_pixel_loc;

endpackage

@@ rtl/core/lmfs_cmd_if.sv @@
interface lmfs_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          command;
    logic signed [lmfs_pkg::COORD_W-1:0] x_pos;
    logic signed [lmfs_pkg::COORD_W-1:0] y_pos;
    logic                                pixel_on;

    modport source (output valid, command, x_pos, y_pos, pixel_on, input ready);
    modport sink   (input valid, command, x_pos, y_pos, pixel_on, output ready);
endinterface

@@ rtl/core/lmfs_scan_if.sv @@
interface lmfs_scan_if;
    logic                              valid;
    logic                              ready;
    logic [lmfs_pkg::WORD_BITS-1:0]    scan_word;
    logic                              last_word;

    modport source (output valid, scan_word, last_word, input ready);
    modport sink   (input valid, scan_word, last_word, output ready);
endinterface

@@ rtl/core/lmfs_ram.sv @@
module lmfs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

@@ rtl/core/lmfs_map.sv @@
module lmfs_map (
    input  logic signed [lmfs_pkg::COORD_W-1:0] i_x_pos,
    input  logic signed [lmfs_pkg::COORD_W-1:0] i_y_pos,
    output lmfs_pkg::t_pixel_loc                o_loc
);
    import lmfs_pkg::*;

    logic [7:0]        base;
    logic [BIT_AW-1:0] offset;

    // Chain position = base -/+ 16*(7 - y%8); low nibble is the word,
    // high nibble the bit, so only the high nibble moves.
    always_comb begin
        base   = i_y_pos[3] ? LOWER_BASE[i_x_pos[3:0]] : UPPER_BASE[i_x_pos[3:0]];
        offset = {1'b0, 3'd7 - i_y_pos[2:0]};
        o_loc.in_range = (i_x_pos[COORD_W-1:4] == '0) && (i_y_pos[COORD_W-1:4] == '0);
        o_loc.word     = base[3:0];
        o_loc.bit_idx  = i_x_pos[0] ? (base[7:4] + offset) : (base[7:4] - offset);
    end
endmodule

@@ rtl/core/led_matrix_framebuffer_scan.sv @@
// Set pixel on the panel: a read, then a modify and write back; off-panel set pixel,
// fill and unused codes finish on acceptance. One command at a time; each ends before the next is taken.
// Scan: 16 beats, one per cycle while the sink holds ready high; the reads are issued from the scan
// state after acceptance, and the next command waits until the last beat has been taken.
// Synchronous active-low reset blanks the panel at once through per-word valid bits;
// no clearing pass is needed.
module led_matrix_framebuffer_scan (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmfs_cmd_if.sink    i_cmd,
    lmfs_scan_if.source o_scan
);
    import lmfs_pkg::*;

    // Control state
    t_state                 r_state, n_state;
    logic [PANEL_WORDS-1:0] r_valid, n_valid;     // word has been written since last fill
    logic                   r_fill_val, n_fill_val; // value of every unwritten word
    logic [WORD_AW:0]       r_cnt, n_cnt;         // scan read pointer, MSB = all issued
    logic                   r_pend, n_pend;       // a scan beat sits on the RAM read register

    // Payload
    logic                   r_rd_vld, n_rd_vld;   // valid bit of the word just read
    logic                   r_last, n_last;
    logic [WORD_AW-1:0]     r_wr_word, n_wr_word;
    logic [BIT_AW-1:0]      r_wr_bit, n_wr_bit;
    logic                   r_wr_on, n_wr_on;

    t_pixel_loc             loc;
    logic                   cmd_acc;
    logic                   out_acc;
    logic                   issue;
    logic                   rd_en;
    logic [WORD_AW-1:0]     rd_addr;
    logic                   wr_en;
    logic [WORD_BITS-1:0]   wr_data;
    logic [WORD_BITS-1:0]   rd_data;
    logic [WORD_BITS-1:0]   cur_word;
    logic [WORD_BITS-1:0]   bit_mask;

    lmfs_map u_map (
        .i_x_pos (i_cmd.x_pos),
        .i_y_pos (i_cmd.y_pos),
        .o_loc   (loc)
    );

    lmfs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (PANEL_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wr_word),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshakes: the scan beat is driven straight from the RAM read register,
    // so a new command waits until the last beat has gone.
    assign i_cmd.ready      = (r_state == ST_IDLE) && !r_pend;
    assign cmd_acc          = i_cmd.valid && i_cmd.ready;
    assign o_scan.valid     = r_pend;
    assign out_acc          = r_pend && o_scan.ready;

    // Unwritten words read as the last fill value.
    assign cur_word         = r_rd_vld ? rd_data : {WORD_BITS{r_fill_val}};
    assign o_scan.scan_word = cur_word;
    assign o_scan.last_word = r_last;
    assign bit_mask         = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_wr_bit;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_acc) begin
                    case (t_cmd'(i_cmd.command))
                        CMD_SET_PIXEL: if (loc.in_range) n_state = ST_MODIFY;
                        CMD_SCAN:      n_state = ST_SCAN;
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MODIFY: n_state = ST_IDLE;
            ST_SCAN:   if (r_cnt[WORD_AW]) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Datapath and store control
    always_comb begin
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_data    = cur_word;
        issue      = 1'b0;
        n_valid    = r_valid;
        n_fill_val = r_fill_val;
        n_cnt      = r_cnt;
        n_wr_word  = r_wr_word;
        n_wr_bit   = r_wr_bit;
        n_wr_on    = r_wr_on;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_acc) begin
                    case (t_cmd'(i_cmd.command))
                        CMD_SET_PIXEL: begin
                            rd_en     = loc.in_range;
                            rd_addr   = loc.word;
                            n_wr_word = loc.word;
                            n_wr_bit  = loc.bit_idx;
                            n_wr_on   = i_cmd.pixel_on;
                        end
                        CMD_FILL: begin
                            n_valid    = '0;
                            n_fill_val = i_cmd.pixel_on;
                        end
                        CMD_SCAN: n_cnt = '0;
                        default: ;
                    endcase
                end
            end
            ST_MODIFY: begin
                wr_en              = 1'b1;
                wr_data            = r_wr_on ? (cur_word | bit_mask) : (cur_word & ~bit_mask);
                n_valid[r_wr_word] = 1'b1;
            end
            ST_SCAN: begin
                // Next read may replace the beat on the read register once it is taken.
                issue   = !r_cnt[WORD_AW] && (!r_pend || out_acc);
                rd_en   = issue;
                rd_addr = r_cnt[WORD_AW-1:0];
                if (issue) n_cnt = r_cnt + 1'b1;
            end
            default: ;
        endcase
        n_rd_vld = rd_en ? r_valid[rd_addr] : r_rd_vld;
        n_last   = issue ? (r_cnt[WORD_AW-1:0] == WORD_AW'(PANEL_WORDS - 1)) : r_last;
        n_pend   = issue ? 1'b1 : (out_acc ? 1'b0 : r_pend);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_fill_val <= 1'b0;
            r_cnt      <= '0;
            r_pend     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_fill_val <= n_fill_val;
            r_cnt      <= n_cnt;
            r_pend     <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld  <= n_rd_vld;
        r_last    <= n_last;
        r_wr_word <= n_wr_word;
        r_wr_bit  <= n_wr_bit;
        r_wr_on   <= n_wr_on;
    end
endmodule
